>>> rtl/gfau_pkg.sv
// gfau_pkg: shared types, microcode ROM and GF(2^8) multiply for the GF(2^8) arithmetic unit.
// No dependencies; imported by gfau_seq, gfau_dp and gf256_arith_unit_core.
`timescale 1ns / 1ps

package gfau_pkg;

    // Reset value of the reduction polynomial low byte (x^8 + x^6 + x^5 + x^3 + 1)
    localparam logic [7:0] RESET_POLY = 8'h69;
    localparam logic [7:0] GF_ONE     = 8'h01;
    localparam logic [7:0] GF_ZERO    = 8'h00;
    localparam logic [7:0] CNT_LAST   = 8'hFF;

    typedef enum logic [1:0] {
        OP_MUL = 2'd0,
        OP_POW = 2'd1,
        OP_INV = 2'd2,
        OP_RSV = 2'd3
    } t_opcode;

    // Microcode addresses
    typedef enum logic [3:0] {
        UA_IDLE  = 4'd0,
        UA_MUL   = 4'd1,
        UA_POW0  = 4'd2,
        UA_POWL  = 4'd3,
        UA_PONE  = 4'd4,
        UA_INV0  = 4'd5,
        UA_INVL  = 4'd6,
        UA_IFAIL = 4'd7,
        UA_RSV   = 4'd8,
        UA_DONE  = 4'd9
    } t_upc;

    typedef enum logic [2:0] {
        ACC_HOLD = 3'd0,
        ACC_PROD = 3'd1,
        ACC_A    = 3'd2,
        ACC_ONE  = 3'd3,
        ACC_ZERO = 3'd4,
        ACC_CNT  = 3'd5
    } t_acc_sel;

    typedef enum logic [1:0] {
        MUL_A_B   = 2'd0,
        MUL_ACC_A = 2'd1,
        MUL_A_CNT = 2'd2
    } t_mul_sel;

    typedef enum logic [1:0] {
        CNT_HOLD = 2'd0,
        CNT_ONE  = 2'd1,
        CNT_INC  = 2'd2
    } t_cnt_op;

    typedef enum logic [2:0] {
        C_NEVER      = 3'd0,
        C_B_ZERO     = 3'd1,
        C_B_ONE      = 3'd2,
        C_CNT_NEXT_B = 3'd3,
        C_PROD_ONE   = 3'd4,
        C_CNT_LAST   = 3'd5,
        C_OUT_FREE   = 3'd6
    } t_cond;

    // One control word: datapath fields, two prioritized conditional jumps, default next
    typedef struct packed {
        t_acc_sel acc_sel;
        t_mul_sel mul_sel;
        t_cnt_op  cnt_op;
        logic     flag_set;
        logic     emit;
        logic     dispatch;
        t_cond    c1;
        t_upc     t1;
        t_cond    c2;
        t_upc     t2;
        t_upc     nxt;
    } t_uword;

    // Sequencer to datapath
    typedef struct packed {
        t_acc_sel acc_sel;
        t_mul_sel mul_sel;
        t_cnt_op  cnt_op;
        logic     flag_set;
        logic     load;
        logic     emit;
    } t_dp_ctrl;

    // Datapath to sequencer
    typedef struct packed {
        logic b_zero;
        logic b_one;
        logic cnt_next_b;
        logic prod_one;
        logic cnt_last;
        logic out_free;
    } t_dp_stat;

    localparam t_uword UW_NOP = '{
        acc_sel:  ACC_HOLD,
        mul_sel:  MUL_A_B,
        cnt_op:   CNT_HOLD,
        flag_set: 1'b0,
        emit:     1'b0,
        dispatch: 1'b0,
        c1:       C_NEVER,
        t1:       UA_IDLE,
        c2:       C_NEVER,
        t2:       UA_IDLE,
        nxt:      UA_IDLE
    };

    // Shift-and-xor multiply; y is shifted and reduced, x selects the partial terms
    function automatic logic [7:0] gf_mul(input logic [7:0] x, input logic [7:0] y,
                                          input logic [7:0] poly);
        logic [7:0] acc;
        logic [7:0] m;
        acc = GF_ZERO;
        m   = y;
        for (int k = 0; k < 8; k++) begin
            if (x[k]) begin
                acc = acc ^ m;
            end
            m = m[7] ? ({m[6:0], 1'b0} ^ poly) : {m[6:0], 1'b0};
        end
        return acc;
    endfunction

    // Entry point of each operation's routine
    function automatic t_upc op_entry(input t_opcode op);
        t_upc e;
        case (op)
            OP_MUL:  e = UA_MUL;
            OP_POW:  e = UA_POW0;
            OP_INV:  e = UA_INV0;
            default: e = UA_RSV;
        endcase
        return e;
    endfunction

    // Microcode program
    function automatic t_uword ucode_rom(input t_upc pc);
        t_uword w;
        w = UW_NOP;
        case (pc)
            UA_IDLE: begin
                w.dispatch = 1'b1;
            end
            // product of a and b
            UA_MUL: begin
                w.acc_sel = ACC_PROD;
                w.mul_sel = MUL_A_B;
                w.nxt     = UA_DONE;
            end
            // power: zero exponent gives one, exponent one gives the base
            UA_POW0: begin
                w.acc_sel = ACC_A;
                w.cnt_op  = CNT_ONE;
                w.c1      = C_B_ZERO;
                w.t1      = UA_PONE;
                w.c2      = C_B_ONE;
                w.t2      = UA_DONE;
                w.nxt     = UA_POWL;
            end
            // power loop: acc *= a until count reaches the exponent
            UA_POWL: begin
                w.acc_sel = ACC_PROD;
                w.mul_sel = MUL_ACC_A;
                w.cnt_op  = CNT_INC;
                w.c1      = C_CNT_NEXT_B;
                w.t1      = UA_DONE;
                w.nxt     = UA_POWL;
            end
            UA_PONE: begin
                w.acc_sel = ACC_ONE;
                w.nxt     = UA_DONE;
            end
            UA_INV0: begin
                w.cnt_op = CNT_ONE;
                w.nxt    = UA_INVL;
            end
            // inverse search: one trial multiplier per step
            UA_INVL: begin
                w.acc_sel = ACC_CNT;
                w.mul_sel = MUL_A_CNT;
                w.cnt_op  = CNT_INC;
                w.c1      = C_PROD_ONE;
                w.t1      = UA_DONE;
                w.c2      = C_CNT_LAST;
                w.t2      = UA_IFAIL;
                w.nxt     = UA_INVL;
            end
            UA_IFAIL: begin
                w.acc_sel  = ACC_ZERO;
                w.flag_set = 1'b1;
                w.nxt      = UA_DONE;
            end
            UA_RSV: begin
                w.acc_sel = ACC_ZERO;
                w.nxt     = UA_DONE;
            end
            // hand result to the output register once it is free
            UA_DONE: begin
                w.emit = 1'b1;
                w.c1   = C_OUT_FREE;
                w.t1   = UA_IDLE;
                w.nxt  = UA_DONE;
            end
            default: begin
                w.nxt = UA_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

>>> rtl/gfau_seq.sv
// gfau_seq: microcode sequencer (step counter, ROM lookup, conditional jumps, dispatch).
// Depends on gfau_pkg.
`timescale 1ns / 1ps

module gfau_seq
    import gfau_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_opcode,
    input  t_dp_stat   i_stat,
    output t_dp_ctrl   o_ctrl
);

    t_upc   r_pc;
    t_upc   n_pc;
    t_uword w;
    logic   accept;

    assign w = ucode_rom(r_pc);

    // condition test
    function automatic logic cond_true(input t_cond c, input t_dp_stat s);
        logic t;
        case (c)
            C_B_ZERO:     t = s.b_zero;
            C_B_ONE:      t = s.b_one;
            C_CNT_NEXT_B: t = s.cnt_next_b;
            C_PROD_ONE:   t = s.prod_one;
            C_CNT_LAST:   t = s.cnt_last;
            C_OUT_FREE:   t = s.out_free;
            default:      t = 1'b0;
        endcase
        return t;
    endfunction

    // next step
    always_comb begin
        if (w.dispatch) begin
            n_pc = accept ? op_entry(t_opcode'(i_opcode)) : UA_IDLE;
        end else if (cond_true(w.c1, i_stat)) begin
            n_pc = w.t1;
        end else if (cond_true(w.c2, i_stat)) begin
            n_pc = w.t2;
        end else begin
            n_pc = w.nxt;
        end
    end

    // control outputs
    always_comb begin
        o_in_stall      = !w.dispatch;
        accept          = i_in_valid && w.dispatch;
        o_ctrl.acc_sel  = w.acc_sel;
        o_ctrl.mul_sel  = w.mul_sel;
        o_ctrl.cnt_op   = w.cnt_op;
        o_ctrl.flag_set = w.flag_set;
        o_ctrl.load     = accept;
        o_ctrl.emit     = w.emit && i_stat.out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= UA_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    // a transfer in always starts a routine
    a_load_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.load |=> r_pc != UA_IDLE)
        else $error("sequencer stayed idle after input transfer");

    // finishing step returns to dispatch once the result is handed over
    a_done_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == UA_DONE) && i_stat.out_free |=> r_pc == UA_IDLE)
        else $error("sequencer did not return to idle after emit");

endmodule

>>> rtl/gfau_dp.sv
// gfau_dp: datapath with operand, accumulator and counter registers, one shared GF(2^8)
// multiplier and the output register. Depends on gfau_pkg.
`timescale 1ns / 1ps

module gfau_dp
    import gfau_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_poly,
    input  logic [7:0] i_operand_a,
    input  logic [7:0] i_operand_b,
    input  t_dp_ctrl   i_ctrl,
    output t_dp_stat   o_stat,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_result,
    output logic       o_no_inverse
);

    logic [7:0] r_a;
    logic [7:0] r_b;
    logic [7:0] r_acc;
    logic [7:0] r_cnt;
    logic       r_flag;
    logic [7:0] r_res;
    logic       r_nfl;
    logic       r_out_vld;

    logic [7:0] mul_x;
    logic [7:0] mul_y;
    logic [7:0] prod;
    logic [7:0] cnt_inc;
    logic [7:0] n_acc;
    logic [7:0] n_cnt;

    // shared multiplier operand select
    always_comb begin
        case (i_ctrl.mul_sel)
            MUL_ACC_A: begin
                mul_x = r_acc;
                mul_y = r_a;
            end
            MUL_A_CNT: begin
                mul_x = r_a;
                mul_y = r_cnt;
            end
            default: begin
                mul_x = r_a;
                mul_y = r_b;
            end
        endcase
    end

    assign prod    = gf_mul(mul_x, mul_y, i_poly);
    assign cnt_inc = 8'(r_cnt + 8'd1);

    // accumulator and counter next values
    always_comb begin
        case (i_ctrl.acc_sel)
            ACC_PROD: n_acc = prod;
            ACC_A:    n_acc = r_a;
            ACC_ONE:  n_acc = GF_ONE;
            ACC_ZERO: n_acc = GF_ZERO;
            ACC_CNT:  n_acc = r_cnt;
            default:  n_acc = r_acc;
        endcase
        case (i_ctrl.cnt_op)
            CNT_ONE: n_cnt = GF_ONE;
            CNT_INC: n_cnt = cnt_inc;
            default: n_cnt = r_cnt;
        endcase
    end

    // status for jumps
    always_comb begin
        o_stat.b_zero     = (r_b == GF_ZERO);
        o_stat.b_one      = (r_b == GF_ONE);
        o_stat.cnt_next_b = (cnt_inc == r_b);
        o_stat.prod_one   = (prod == GF_ONE);
        o_stat.cnt_last   = (r_cnt == CNT_LAST);
        o_stat.out_free   = !r_out_vld || !i_out_stall;
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_a <= i_operand_a;
            r_b <= i_operand_b;
        end
        r_acc <= n_acc;
        r_cnt <= n_cnt;
        if (i_ctrl.load) begin
            r_flag <= 1'b0;
        end else if (i_ctrl.flag_set) begin
            r_flag <= 1'b1;
        end
        if (i_ctrl.emit) begin
            r_res <= r_acc;
            r_nfl <= r_flag;
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_ctrl.emit) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_result     = r_res;
    assign o_no_inverse = r_nfl;

    // never overwrite a result still waiting
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.emit |-> (!r_out_vld || !i_out_stall))
        else $error("result overwritten while output stalled");

    // failed inverse always reports zero
    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_nfl |-> r_res == GF_ZERO)
        else $error("no_inverse set with nonzero result");

endmodule

>>> rtl/gf256_arith_unit_core.sv
// gf256_arith_unit_core: top level of the GF(2^8) multiply / power / inverse unit.
// Depends on gfau_pkg, gfau_seq and gfau_dp.
//
//  Channel  Handshake                     Payload
//  ------   ---------------------------   -----------------------------------------
//  in       i_in_valid / o_in_stall       i_opcode, i_operand_a, i_operand_b
//  out      o_out_valid / i_out_stall     o_result, o_no_inverse
//  cfg      i_cfg_wr_en                   i_cfg_wr_data (reduction polynomial)
//
// Each item runs from the dispatch step through its opcode's routine to the emit step;
// power loops up to its exponent and inverse tries each nonzero multiplier in turn.
// One microcode step per cycle, each using the single shared GF multiplier at most once.
// Synchronous active-low reset; the polynomial resets to 0x69.
// Input is taken only at the dispatch step; a finished result sits in the output
// register so the next item can be taken while it waits.
`timescale 1ns / 1ps

module gf256_arith_unit_core
    import gfau_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_opcode,
    input  logic [7:0] i_operand_a,
    input  logic [7:0] i_operand_b,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_result,
    output logic       o_no_inverse
);

    logic [7:0] r_poly;
    t_dp_ctrl   ctrl;
    t_dp_stat   stat;

    // reduction polynomial register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly <= RESET_POLY;
        end else if (i_cfg_wr_en) begin
            r_poly <= i_cfg_wr_data;
        end
    end

    gfau_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_opcode   (i_opcode),
        .i_stat     (stat),
        .o_ctrl     (ctrl)
    );

    gfau_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_poly       (r_poly),
        .i_operand_a  (i_operand_a),
        .i_operand_b  (i_operand_b),
        .i_ctrl       (ctrl),
        .o_stat       (stat),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_result     (o_result),
        .o_no_inverse (o_no_inverse)
    );

endmodule

>>> tb/testbench.sv
// testbench: self-checking bench for gf256_arith_unit_core (GF(2^8) multiply, power, inverse).
// Depends on gfau_pkg and the core RTL. Randomized traffic with idle/stall bursts on both
// channels, compared against a built-in GF(2^8) arithmetic predictor.
`timescale 1ns / 1ps

module testbench;
    import gfau_pkg::*;

    localparam int PHASE_COUNT  = 6;
    localparam int PHASE_ITEMS  = 240;
    localparam int SETTLE_CYC   = 260;
    localparam int WDOG_LIMIT   = 4000;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        t_opcode    op;
        logic [7:0] a;
        logic [7:0] b;
    } t_gf_req;

    typedef struct packed {
        logic [7:0] value;
        logic       no_inv;
    } t_gf_answer;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_cfg_wr_en   = 1'b0;
    logic [7:0] i_cfg_wr_data = 8'h00;
    logic       i_in_valid    = 1'b0;
    logic [1:0] i_opcode      = 2'd0;
    logic [7:0] i_operand_a   = 8'h00;
    logic [7:0] i_operand_b   = 8'h00;
    logic       i_out_stall   = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [7:0] o_result;
    logic       o_no_inverse;

    t_gf_req    gf_req_q[$];
    t_gf_answer answer_q[$];
    logic [7:0] active_poly = RESET_POLY;
    bit         idle_on     = 1'b1;
    int         in_gap_left    = 0;
    int         out_stall_left = 0;
    int         mismatch_cnt   = 0;
    int         quiet_cycles   = 0;

    gf256_arith_unit_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_opcode      (i_opcode),
        .i_operand_a   (i_operand_a),
        .i_operand_b   (i_operand_b),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_result      (o_result),
        .o_no_inverse  (o_no_inverse)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Product in GF(2)[x] / (x^8 + poly), Horner order from the top bit of x
    function automatic logic [7:0] field_mul(input logic [7:0] x, input logic [7:0] y,
                                             input logic [7:0] poly);
        logic [7:0] acc;
        acc = 8'h00;
        for (int k = 7; k >= 0; k--) begin
            acc = acc[7] ? ({acc[6:0], 1'b0} ^ poly) : {acc[6:0], 1'b0};
            if (x[k]) begin
                acc = acc ^ y;
            end
        end
        return acc;
    endfunction

    // Expected answer for one request under the given polynomial
    function automatic t_gf_answer gf_evaluate(input t_gf_req req, input logic [7:0] poly);
        t_gf_answer ans;
        ans.value  = 8'h00;
        ans.no_inv = 1'b0;
        case (req.op)
            OP_MUL: begin
                ans.value = field_mul(req.a, req.b, poly);
            end
            OP_POW: begin
                // zero exponent gives one, even for a zero base
                ans.value = (req.b == 8'h00) ? GF_ONE : req.a;
                for (int k = 1; k < int'(req.b); k++) begin
                    ans.value = field_mul(ans.value, req.a, poly);
                end
            end
            OP_INV: begin
                // first multiplier giving one; none found means flag and zero
                ans.no_inv = 1'b1;
                for (int c = 1; c < 256; c++) begin
                    if (ans.no_inv && field_mul(req.a, c[7:0], poly) == GF_ONE) begin
                        ans.value  = c[7:0];
                        ans.no_inv = 1'b0;
                    end
                end
            end
            default: begin
                ans.value = 8'h00;
            end
        endcase
        return ans;
    endfunction

    // Byte with a bias toward the edge values
    function automatic logic [7:0] pick_byte();
        logic [7:0] v;
        case ($urandom_range(0, 11))
            0:       v = 8'h00;
            1:       v = 8'hFF;
            2:       v = 8'h01;
            3:       v = 8'h80;
            default: v = 8'($urandom_range(0, 255));
        endcase
        return v;
    endfunction

    function automatic void queue_req(input t_opcode op, input logic [7:0] a,
                                      input logic [7:0] b);
        t_gf_req r;
        r.op = op;
        r.a  = a;
        r.b  = b;
        gf_req_q.push_back(r);
    endfunction

    // Wait until every request is transferred and every answer has come back
    task automatic wait_drained();
        while (gf_req_q.size() != 0 || i_in_valid || answer_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Polynomial currently held by the block
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            active_poly <= RESET_POLY;
        end else if (i_cfg_wr_en) begin
            active_poly <= i_cfg_wr_data;
        end
    end

    // Input driver: predict on each transfer, then present the next request or idle
    always @(posedge i_clk) begin : drive_proc
        t_gf_req seen_req;
        t_gf_req next_req;
        logic    taken;
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            in_gap_left = 0;
        end else begin
            taken = i_in_valid && !o_in_stall;
            if (taken) begin
                seen_req.op = t_opcode'(i_opcode);
                seen_req.a  = i_operand_a;
                seen_req.b  = i_operand_b;
                answer_q.push_back(gf_evaluate(seen_req, active_poly));
            end
            if (!i_in_valid || taken) begin
                if (in_gap_left != 0) begin
                    in_gap_left--;
                    i_in_valid <= 1'b0;
                end else if (idle_on && gf_req_q.size() != 0 && $urandom_range(0, 7) == 0) begin
                    in_gap_left = $urandom_range(1, 10) - 1;
                    i_in_valid <= 1'b0;
                end else if (gf_req_q.size() != 0) begin
                    next_req = gf_req_q.pop_front();
                    i_in_valid  <= 1'b1;
                    i_opcode    <= next_req.op;
                    i_operand_a <= next_req.a;
                    i_operand_b <= next_req.b;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: compare each transfer with the oldest answer, drive stall bursts
    always @(posedge i_clk) begin : check_proc
        t_gf_answer want;
        if (!i_rst_n) begin
            i_out_stall    <= 1'b0;
            out_stall_left = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (answer_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_LIMIT) begin
                        $display("unexpected result: result=%02h no_inverse=%b",
                                 o_result, o_no_inverse);
                    end
                end else begin
                    want = answer_q.pop_front();
                    if (o_result !== want.value || o_no_inverse !== want.no_inv) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= REPORT_LIMIT) begin
                            $display("mismatch: result exp=%02h got=%02h, no_inverse exp=%b got=%b",
                                     want.value, o_result, want.no_inv, o_no_inverse);
                        end
                    end
                end
            end
            if (out_stall_left != 0) begin
                out_stall_left--;
                i_out_stall <= 1'b1;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                out_stall_left = $urandom_range(1, 10) - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Watchdog on cycles with no transfer of any kind
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_wr_en) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WDOG_LIMIT) begin
            $display("gf256_arith_unit_core verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus sequence
    initial begin : stim_proc
        logic [7:0] poly;
        t_opcode    op;
        int         sel;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: operand extremes, every opcode, zero exponent, missing inverse
        queue_req(OP_MUL, 8'h00, 8'h00);
        queue_req(OP_MUL, 8'hFF, 8'hFF);
        queue_req(OP_MUL, 8'h01, 8'hFF);
        queue_req(OP_MUL, 8'hFF, 8'h01);
        queue_req(OP_MUL, 8'h80, 8'h80);
        queue_req(OP_MUL, 8'h80, 8'h02);
        queue_req(OP_POW, 8'h00, 8'h00);
        queue_req(OP_POW, 8'hFF, 8'h00);
        queue_req(OP_POW, 8'h00, 8'h01);
        queue_req(OP_POW, 8'h02, 8'h01);
        queue_req(OP_POW, 8'h03, 8'h02);
        queue_req(OP_POW, 8'h02, 8'hFE);
        queue_req(OP_POW, 8'hFF, 8'hFF);
        queue_req(OP_INV, 8'h00, 8'h00);
        queue_req(OP_INV, 8'h01, 8'h00);
        queue_req(OP_INV, 8'hFF, 8'hFF);
        queue_req(OP_INV, 8'h80, 8'h55);
        queue_req(OP_INV, 8'h02, 8'hAA);
        queue_req(OP_RSV, 8'hFF, 8'hFF);
        queue_req(OP_RSV, 8'h00, 8'h00);

        // Random phases, each under its own polynomial; last phase runs without idling
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            wait_drained();
            repeat (4) @(posedge i_clk);
            case (ph)
                0:       poly = 8'h1B;
                1:       poly = 8'h00;
                2:       poly = 8'hFF;
                4:       poly = RESET_POLY;
                default: poly = 8'($urandom_range(1, 254));
            endcase
            i_cfg_wr_en   <= 1'b1;
            i_cfg_wr_data <= poly;
            @(posedge i_clk);
            i_cfg_wr_en <= 1'b0;
            idle_on = (ph != PHASE_COUNT - 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                sel = $urandom_range(0, 15);
                op  = (sel < 5) ? OP_MUL : (sel < 10) ? OP_POW : (sel < 15) ? OP_INV : OP_RSV;
                queue_req(op, pick_byte(), pick_byte());
            end
        end

        wait_drained();
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (mismatch_cnt == 0 && answer_q.size() == 0) begin
            $display("gf256_arith_unit_core verification clean");
        end else begin
            $display("gf256_arith_unit_core verification failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/gfau_pkg.sv
rtl/gfau_seq.sv
rtl/gfau_dp.sv
rtl/gf256_arith_unit_core.sv
tb/testbench.sv
